@@ design/spt_pkg.sv @@
// ----------------------------------------------------------------------------
// spt_pkg: shared types and constants of the sparse polynomial term table
// sizes of the term table, operation codes, register map and the types that
// pass between the sequencer and the shared arithmetic unit
// ----------------------------------------------------------------------------
package spt_pkg;

  localparam int MAX_TERMS = 16;
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int COEF_W    = 32;
  localparam int EXP_W     = 16;
  localparam int WORD_W    = COEF_W + EXP_W;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);

  // operation codes
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_SUB  = 2'd1;
  localparam logic [1:0] OP_MUL  = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  // register index as seen in paddr[2]
  localparam logic REG_ASCENDING = 1'b0;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_MUL,
    ALU_CMP,
    ALU_MAG
  } alu_op_e;

  typedef struct packed {
    alu_op_e             op;
    logic [COEF_W-1:0]   a;
    logic [COEF_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [COEF_W-1:0]   value;
    logic                zero;
    logic                lt;
    logic                eq;
    logic                gt;
    logic                fits;
  } alu_rsp_t;

  typedef struct packed {
    logic [COEF_W-1:0]   coef;
    logic [EXP_W-1:0]    expo;
  } term_t;

endpackage

@@ design/spt_ram.sv @@
// ----------------------------------------------------------------------------
// spt_ram: generic single write, single read memory
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module spt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 48,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/spt_alu.sv @@
// ----------------------------------------------------------------------------
// spt_alu: shared arithmetic unit of the term table
// add, low-half multiply, signed compare and magnitude compare, one request
// per cycle with the response registered
// ----------------------------------------------------------------------------
module spt_alu (
  input  logic              clk_i,
  input  spt_pkg::alu_req_t req_i,
  output spt_pkg::alu_rsp_t rsp_o
);
  import spt_pkg::*;

  logic [COEF_W-1:0]   product;
  logic [COEF_W-1:0]   mag_a;
  logic [COEF_W-1:0]   mag_b;
  alu_rsp_t            rsp_d;
  alu_rsp_t            rsp_q;

  assign product = req_i.a * req_i.b;
  assign mag_a   = req_i.a[COEF_W-1] ? (~req_i.a + 1'b1) : req_i.a;
  assign mag_b   = req_i.b[COEF_W-1] ? (~req_i.b + 1'b1) : req_i.b;

  always_comb begin
    rsp_d = '0;
    case (req_i.op)
      ALU_ADD: begin
        rsp_d.value = req_i.a + req_i.b;
      end
      ALU_MUL: begin
        rsp_d.value = product;
      end
      ALU_CMP: begin
        rsp_d.lt = $signed(req_i.a) < $signed(req_i.b);
        rsp_d.eq = req_i.a == req_i.b;
      end
      ALU_MAG: begin
        rsp_d.gt = mag_a > mag_b;
      end
      default: begin
        rsp_d.value = '0;
      end
    endcase
    rsp_d.zero = rsp_d.value == '0;
    // result fits a 16-bit exponent
    rsp_d.fits = (&rsp_d.value[COEF_W-1:EXP_W-1]) | ~(|rsp_d.value[COEF_W-1:EXP_W-1]);
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

endmodule

@@ design/sparse_polynomial_term_table_unit.sv @@
// ----------------------------------------------------------------------------
// sparse_polynomial_term_table_unit: sparse polynomial term table
// holds up to MAX_TERMS nonzero terms sorted by exponent; adds, subtracts,
// multiplies by a term and reads out all terms under a small sequencer
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i/in_stall_o   opcode, coefficient, exponent
//   out      source     out_valid_o/out_stall_i term, degree, count, flags
//   cfg      sink       apb psel/penable        ascending_order at 0x0
//
// one table entry is visited per memory read: searches, range checks, multiply
// and degree scans pass each entry through read, shared unit and act; shifts and
// read-out through read and write or output; an order change reads and writes
// back each swapped pair, then rescans the degree; the pace is set by the single
// read port of the term memory and the registered shared unit
// reset clears the term count, degree and order; the memory is not cleared
// in_stall_o is high while an item or a re-ordering is in progress;
// out_stall_i holds the sequencer at its next beat
// ----------------------------------------------------------------------------
module sparse_polynomial_term_table_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      opcode_i,
  input  logic signed [31:0]              term_coefficient_i,
  input  logic signed [15:0]              term_exponent_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [31:0]              out_coefficient_o,
  output logic signed [15:0]              out_exponent_o,
  output logic signed [15:0]              poly_degree_o,
  output logic [4:0]                      term_count_o,
  output logic                            overflow_o,
  output logic                            last_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [spt_pkg::PADDR_W-1:0]     paddr,
  input  logic [spt_pkg::PDATA_W-1:0]     pwdata,
  output logic [spt_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);
  import spt_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_EX    = 4'd2;
  localparam logic [3:0] S_ACT   = 4'd3;
  localparam logic [3:0] S_MRG   = 4'd4;
  localparam logic [3:0] S_MRGWB = 4'd5;
  localparam logic [3:0] S_INS   = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;
  localparam logic [3:0] S_RV_WA = 4'd8;
  localparam logic [3:0] S_RV_WB = 4'd9;

  localparam logic [2:0] P_SRCH = 3'd0;
  localparam logic [2:0] P_RNG  = 3'd1;
  localparam logic [2:0] P_MUL  = 3'd2;
  localparam logic [2:0] P_DEG  = 3'd3;
  localparam logic [2:0] P_OUT  = 3'd4;
  localparam logic [2:0] P_SHUP = 3'd5;
  localparam logic [2:0] P_SHDN = 3'd6;
  localparam logic [2:0] P_REV  = 3'd7;

  logic [3:0]        state_q, state_d;
  logic [2:0]        pass_q, pass_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  aux_q, aux_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [EXP_W-1:0]  deg_q, deg_d;
  logic              asc_q, asc_d;
  logic              phys_q, phys_d;
  logic              cfg_run_q, cfg_run_d;
  logic              ovf_q, ovf_d;
  logic [COEF_W-1:0] op_coef_q, op_coef_d;
  logic [EXP_W-1:0]  op_exp_q, op_exp_d;
  term_t             tmp_q, tmp_d;

  logic              out_valid_q, out_valid_d;
  logic [COEF_W-1:0] out_coef_q;
  logic [EXP_W-1:0]  out_exp_q;
  logic [EXP_W-1:0]  out_deg_q;
  logic [CNT_W-1:0]  out_cnt_q;
  logic              out_ovf_q;
  logic              out_last_q;

  logic              out_load;
  logic [COEF_W-1:0] beat_coef;
  logic [EXP_W-1:0]  beat_exp;
  logic              beat_last;
  logic              slot_free;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  term_t             mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  term_t             rd;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  logic              accept;
  logic              cfg_we;
  logic              deg_start;
  logic              ins_start;
  logic [CNT_W-1:0]  ins_pos;
  logic              goes_first;
  logic [CNT_W-1:0]  idx_inc, idx_dec, aux_inc, aux_dec;
  logic [COEF_W-1:0] in_coef;

  spt_ram #(
    .DEPTH (MAX_TERMS),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd)
  );

  spt_alu u_alu (
    .clk_i (clk_i),
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[PADDR_W-1] == REG_ASCENDING);
  assign prdata = (paddr[PADDR_W-1] == REG_ASCENDING) ?
                  {{(PDATA_W-1){1'b0}}, asc_q} : '0;

  assign in_stall_o = !((state_q == S_IDLE) && (asc_q == phys_q));
  assign accept     = in_valid_i & ~in_stall_o;
  assign slot_free  = ~out_valid_q | ~out_stall_i;

  assign idx_inc = idx_q + CNT_ONE;
  assign idx_dec = idx_q - CNT_ONE;
  assign aux_inc = aux_q + CNT_ONE;
  assign aux_dec = aux_q - CNT_ONE;
  assign in_coef = (opcode_i == OP_SUB) ? (~term_coefficient_i + 1'b1) : term_coefficient_i;
  assign goes_first = phys_q ? alu_rsp.lt : (~alu_rsp.lt & ~alu_rsp.eq);

  always_comb begin
    state_d   = state_q;
    pass_d    = pass_q;
    idx_d     = idx_q;
    aux_d     = aux_q;
    n_d       = n_q;
    deg_d     = deg_q;
    asc_d     = cfg_we ? pwdata[0] : asc_q;
    phys_d    = phys_q;
    cfg_run_d = cfg_run_q;
    ovf_d     = ovf_q;
    op_coef_d = op_coef_q;
    op_exp_d  = op_exp_q;
    tmp_d     = tmp_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q[IDX_W-1:0];
    mem_wdata = rd;
    mem_re    = 1'b0;
    mem_raddr = idx_q[IDX_W-1:0];
    alu_req   = '{op: ALU_ADD, a: '0, b: '0};
    out_load  = 1'b0;
    beat_coef = '0;
    beat_exp  = '0;
    beat_last = 1'b1;
    deg_start = 1'b0;
    ins_start = 1'b0;
    ins_pos   = '0;

    case (state_q)
      S_IDLE: begin
        if (asc_q != phys_q) begin
          phys_d    = asc_q;
          cfg_run_d = 1'b1;
          if (n_q > CNT_ONE) begin
            pass_d  = P_REV;
            idx_d   = '0;
            aux_d   = n_q - CNT_ONE;
            state_d = S_RD;
          end else begin
            deg_start = 1'b1;
          end
        end else if (accept) begin
          cfg_run_d = 1'b0;
          ovf_d     = 1'b0;
          op_coef_d = in_coef;
          op_exp_d  = term_exponent_i;
          idx_d     = '0;
          case (opcode_i)
            OP_ADD, OP_SUB: begin
              if (in_coef == '0) begin
                state_d = S_EMIT;
              end else if (n_q == '0) begin
                ins_start = 1'b1;
              end else begin
                pass_d  = P_SRCH;
                state_d = S_RD;
              end
            end
            OP_MUL: begin
              if (in_coef == '0) begin
                n_d     = '0;
                deg_d   = '0;
                state_d = S_EMIT;
              end else if (n_q == '0) begin
                state_d = S_EMIT;
              end else begin
                pass_d  = P_RNG;
                state_d = S_RD;
              end
            end
            default: begin
              if (n_q == '0) begin
                state_d = S_EMIT;
              end else begin
                pass_d  = P_OUT;
                state_d = S_RD;
              end
            end
          endcase
        end
      end

      S_RD: begin
        mem_re = 1'b1;
        case (pass_q)
          P_SHUP:  mem_raddr = idx_dec[IDX_W-1:0];
          P_SHDN:  mem_raddr = idx_inc[IDX_W-1:0];
          default: mem_raddr = idx_q[IDX_W-1:0];
        endcase
        state_d = S_EX;
      end

      S_EX: begin
        case (pass_q)
          P_SRCH: begin
            alu_req = '{op: ALU_CMP, a: {{(COEF_W-EXP_W){rd.expo[EXP_W-1]}}, rd.expo},
                        b: {{(COEF_W-EXP_W){op_exp_q[EXP_W-1]}}, op_exp_q}};
            state_d = S_ACT;
          end
          P_RNG: begin
            alu_req = '{op: ALU_ADD, a: {{(COEF_W-EXP_W){rd.expo[EXP_W-1]}}, rd.expo},
                        b: {{(COEF_W-EXP_W){op_exp_q[EXP_W-1]}}, op_exp_q}};
            state_d = S_ACT;
          end
          P_MUL: begin
            alu_req = '{op: ALU_MUL, a: rd.coef, b: op_coef_q};
            state_d = S_ACT;
          end
          P_DEG: begin
            alu_req = '{op: ALU_MAG, a: {{(COEF_W-EXP_W){rd.expo[EXP_W-1]}}, rd.expo},
                        b: {{(COEF_W-EXP_W){deg_q[EXP_W-1]}}, deg_q}};
            state_d = S_ACT;
          end
          P_OUT: begin
            if (slot_free) begin
              out_load  = 1'b1;
              beat_coef = rd.coef;
              beat_exp  = rd.expo;
              beat_last = idx_inc == n_q;
              idx_d     = idx_inc;
              state_d   = (idx_inc == n_q) ? S_IDLE : S_RD;
            end
          end
          P_SHUP: begin
            mem_we    = 1'b1;
            mem_waddr = idx_q[IDX_W-1:0];
            mem_wdata = rd;
            idx_d     = idx_dec;
            state_d   = (idx_dec == aux_q) ? S_INS : S_RD;
          end
          P_SHDN: begin
            mem_we    = 1'b1;
            mem_waddr = idx_q[IDX_W-1:0];
            mem_wdata = rd;
            idx_d     = idx_inc;
            if ((idx_inc + CNT_ONE) < n_q) begin
              state_d = S_RD;
            end else begin
              n_d       = n_q - CNT_ONE;
              deg_start = 1'b1;
            end
          end
          default: begin
            // first half of a swap: hold entry i, fetch entry j
            tmp_d     = rd;
            mem_re    = 1'b1;
            mem_raddr = aux_q[IDX_W-1:0];
            state_d   = S_RV_WA;
          end
        endcase
      end

      S_ACT: begin
        case (pass_q)
          P_SRCH: begin
            if (goes_first) begin
              if (idx_inc == n_q) begin
                ins_start = 1'b1;
                ins_pos   = n_q;
              end else begin
                idx_d   = idx_inc;
                state_d = S_RD;
              end
            end else if (alu_rsp.eq) begin
              state_d = S_MRG;
            end else begin
              ins_start = 1'b1;
              ins_pos   = idx_q;
            end
          end
          P_RNG: begin
            if (!alu_rsp.fits) begin
              ovf_d   = 1'b1;
              state_d = S_EMIT;
            end else if (idx_inc == n_q) begin
              pass_d  = P_MUL;
              idx_d   = '0;
              aux_d   = '0;
              state_d = S_RD;
            end else begin
              idx_d   = idx_inc;
              state_d = S_RD;
            end
          end
          P_MUL: begin
            if (!alu_rsp.zero) begin
              mem_we    = 1'b1;
              mem_waddr = aux_q[IDX_W-1:0];
              mem_wdata = '{coef: alu_rsp.value, expo: rd.expo + op_exp_q};
              aux_d     = aux_inc;
            end
            if (idx_inc == n_q) begin
              n_d       = alu_rsp.zero ? aux_q : aux_inc;
              deg_start = 1'b1;
            end else begin
              idx_d   = idx_inc;
              state_d = S_RD;
            end
          end
          default: begin
            if ((n_q == CNT_ONE) || alu_rsp.gt) begin
              deg_d = rd.expo;
            end
            if (idx_inc == n_q) begin
              state_d = cfg_run_q ? S_IDLE : S_EMIT;
            end else begin
              idx_d   = idx_inc;
              state_d = S_RD;
            end
          end
        endcase
      end

      S_MRG: begin
        alu_req = '{op: ALU_ADD, a: rd.coef, b: op_coef_q};
        state_d = S_MRGWB;
      end

      S_MRGWB: begin
        if (alu_rsp.zero) begin
          pass_d = P_SHDN;
          if (idx_inc < n_q) begin
            state_d = S_RD;
          end else begin
            n_d       = n_q - CNT_ONE;
            deg_start = 1'b1;
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = idx_q[IDX_W-1:0];
          mem_wdata = '{coef: alu_rsp.value, expo: rd.expo};
          deg_start = 1'b1;
        end
      end

      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = aux_q[IDX_W-1:0];
        mem_wdata = '{coef: op_coef_q, expo: op_exp_q};
        n_d       = n_q + CNT_ONE;
        deg_start = 1'b1;
      end

      S_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      S_RV_WA: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[IDX_W-1:0];
        mem_wdata = rd;
        state_d   = S_RV_WB;
      end

      S_RV_WB: begin
        mem_we    = 1'b1;
        mem_waddr = aux_q[IDX_W-1:0];
        mem_wdata = tmp_q;
        idx_d     = idx_inc;
        aux_d     = aux_dec;
        if (idx_inc < aux_dec) begin
          state_d = S_RD;
        end else begin
          deg_start = 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // new exponent: open a slot at ins_pos by shifting the tail up, or flag overflow when the table is full
    if (ins_start) begin
      if (n_q == CNT_MAX) begin
        ovf_d   = 1'b1;
        state_d = S_EMIT;
      end else begin
        pass_d  = P_SHUP;
        aux_d   = ins_pos;
        idx_d   = n_q;
        state_d = (n_q == ins_pos) ? S_INS : S_RD;
      end
    end

    // rescan for the degree
    if (deg_start) begin
      deg_d  = '0;
      idx_d  = '0;
      pass_d = P_DEG;
      if (n_d == '0) begin
        state_d = cfg_run_q | cfg_run_d ? S_IDLE : S_EMIT;
      end else begin
        state_d = S_RD;
      end
    end
  end

  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= P_SRCH;
      idx_q       <= '0;
      aux_q       <= '0;
      n_q         <= '0;
      deg_q       <= '0;
      asc_q       <= 1'b0;
      phys_q      <= 1'b0;
      cfg_run_q   <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      idx_q       <= idx_d;
      aux_q       <= aux_d;
      n_q         <= n_d;
      deg_q       <= deg_d;
      asc_q       <= asc_d;
      phys_q      <= phys_d;
      cfg_run_q   <= cfg_run_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_coef_q <= op_coef_d;
    op_exp_q  <= op_exp_d;
    tmp_q     <= tmp_d;
    if (out_load) begin
      out_coef_q <= beat_coef;
      out_exp_q  <= beat_exp;
      out_deg_q  <= deg_q;
      out_cnt_q  <= n_q;
      out_ovf_q  <= (state_q == S_EMIT) ? ovf_q : 1'b0;
      out_last_q <= beat_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_coefficient_o = out_coef_q;
  assign out_exponent_o    = out_exp_q;
  assign poly_degree_o     = out_deg_q;
  assign term_count_o      = 5'(out_cnt_q);
  assign overflow_o        = out_ovf_q;
  assign last_o            = out_last_q;

endmodule
